// ----- hw/rtl/fpa_pkg.sv -----
package fpa_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned DataW    = 32;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned DivSteps = DataW + FracBits + 1;

  typedef enum logic [3:0] {
    OpAdd     = 4'd0,
    OpSub     = 4'd1,
    OpMul     = 4'd2,
    OpDiv     = 4'd3,
    OpLt      = 4'd4,
    OpGt      = 4'd5,
    OpGe      = 4'd6,
    OpLe      = 4'd7,
    OpEq      = 4'd8,
    OpNe      = 4'd9,
    OpMin     = 4'd10,
    OpMax     = 4'd11,
    OpFromInt = 4'd12,
    OpToInt   = 4'd13,
    OpInc     = 4'd14,
    OpNone    = 4'd15
  } op_e;

  typedef struct packed {
    logic [3:0]              opcode;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    overflow;
    logic                    divide_by_zero;
  } rsp_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                    is_mul;
    logic                    is_div;
    logic                    dbz;
    logic signed [DataW-1:0] a;
    logic signed [DataW-1:0] b;
    logic signed [DataW-1:0] res;
    logic                    ovf;
  } cmd_t;

endpackage

// ----- hw/rtl/fpa_if.sv -----
interface fpa_req_if;
  import fpa_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fpa_rsp_if;
  import fpa_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/fpa_front.sv -----
module fpa_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fpa_pkg::req_t      in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output fpa_pkg::cmd_t      cmd_o
);
  import fpa_pkg::*;

  logic                    valid_q;
  cmd_t                    cmd_q, cmd_d;
  logic signed [DataW:0]   sum;
  logic signed [DataW:0]   dif;
  logic signed [DataW:0]   incr;
  logic signed [DataW-1:0] a, b;
  logic                    lt, eq;
  logic signed [DataW-1:0] toi;
  logic [FracBits-1:0]     lowbits;
  logic                    fi_ovf;

  assign a    = in_data_i.operand_a;
  assign b    = in_data_i.operand_b;
  assign sum  = {a[DataW-1], a} + {b[DataW-1], b};
  assign dif  = {a[DataW-1], a} - {b[DataW-1], b};
  assign incr = {a[DataW-1], a} + (DataW+1)'(1);
  assign lt   = a < b;
  assign eq   = a == b;
  assign lowbits = a[FracBits-1:0];
  assign toi  = (a >>> FracBits) + ((a[DataW-1] && (lowbits != '0)) ? DataW'(1) : DataW'(0));
  assign fi_ovf = (a[DataW-1:DataW-1-FracBits] != '0) && (a[DataW-1:DataW-1-FracBits] != '1);

  always_comb begin
    cmd_d        = '0;
    cmd_d.a      = a;
    cmd_d.b      = b;
    case (op_e'(in_data_i.opcode))
      OpAdd: begin
        cmd_d.res = sum[DataW-1:0];
        cmd_d.ovf = sum[DataW] ^ sum[DataW-1];
      end
      OpSub: begin
        cmd_d.res = dif[DataW-1:0];
        cmd_d.ovf = dif[DataW] ^ dif[DataW-1];
      end
      OpMul: cmd_d.is_mul = 1'b1;
      OpDiv: begin
        cmd_d.is_div = (b != '0);
        cmd_d.dbz    = (b == '0);
      end
      OpLt:  cmd_d.res = DataW'(lt);
      OpGt:  cmd_d.res = DataW'(!lt && !eq);
      OpGe:  cmd_d.res = DataW'(!lt);
      OpLe:  cmd_d.res = DataW'(lt || eq);
      OpEq:  cmd_d.res = DataW'(eq);
      OpNe:  cmd_d.res = DataW'(!eq);
      OpMin: cmd_d.res = lt ? a : b;
      OpMax: cmd_d.res = lt ? b : a;
      OpFromInt: begin
        cmd_d.res = a <<< FracBits;
        cmd_d.ovf = fi_ovf;
      end
      OpToInt: cmd_d.res = toi;
      OpInc: begin
        cmd_d.res = incr[DataW-1:0];
        cmd_d.ovf = incr[DataW] ^ incr[DataW-1];
      end
      default: cmd_d.res = '0;
    endcase
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !cmd_ready_i |=> valid_q && $stable(cmd_q))
    else $error("front beat dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(cmd_q.is_div && cmd_q.dbz))
    else $error("div and dbz both set");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(cmd_q.is_mul && cmd_q.is_div))
    else $error("mul and div both set");

endmodule

// ----- hw/rtl/fpa_queue.sv -----
module fpa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  fpa_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output fpa_pkg::cmd_t rd_data_o
);
  import fpa_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  cmd_t mem_q [QDepth];
  logic [PtrW-1:0] rp_q, wp_q;
  logic [CntW-1:0] cnt_q;
  logic wr, rd;

  assign wr_ready_o = cnt_q != CntW'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == PtrW'(QDepth - 1)) ? '0 : wp_q + PtrW'(1);
      if (rd) rp_q <= (rp_q == PtrW'(QDepth - 1)) ? '0 : rp_q + PtrW'(1);
      cnt_q <= cnt_q + CntW'(wr) - CntW'(rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth)) else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == CntW'(QDepth)) |-> rp_q == wp_q)
    else $error("queue pointers inconsistent");

endmodule

// ----- hw/rtl/fpa_back.sv -----
module fpa_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  fpa_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fpa_pkg::rsp_t out_data_o
);
  import fpa_pkg::*;

  localparam int unsigned NumW = DataW + FracBits;
  localparam int unsigned PW   = 2 * DataW;
  localparam int unsigned CntW = $clog2(DivSteps + 1);

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StDiv  = 3'b100
  } st_e;

  st_e                  st_q, st_d;
  logic                 ov_q;
  logic                 ov_set;
  rsp_t                 out_q;
  logic [NumW-1:0]      num_q;
  logic [DataW-1:0]     den_q;
  logic [DataW:0]       rem_q;
  logic [NumW-1:0]      quo_q;
  logic [CntW-1:0]      cnt_q;
  logic                 neg_q;
  logic signed [PW-1:0] prod_q;
  logic [DataW-1:0]     ma, mb;
  logic [DataW:0]       rsh;
  logic [DataW:0]       rdiff;
  logic                 take;
  logic                 slot_free;
  logic signed [PW-1:0] pt;
  logic [NumW:0]        qr;
  logic signed [NumW+1:0] sq;
  logic [DataW:0]       r2;
  logic [FracBits-1:0]  plow;

  assign ma = cmd_i.a[DataW-1] ? DataW'(-cmd_i.a) : cmd_i.a;
  assign mb = cmd_i.b[DataW-1] ? DataW'(-cmd_i.b) : cmd_i.b;

  assign slot_free   = !ov_q || out_ready_i;
  assign cmd_ready_o = (st_q == StIdle) && slot_free;
  assign take        = cmd_valid_i && cmd_ready_o;

  assign rsh   = {rem_q[DataW-1:0], num_q[NumW-1]};
  assign rdiff = rsh - {1'b0, den_q};

  assign plow = prod_q[FracBits-1:0];
  assign pt   = (prod_q >>> FracBits) +
                ((prod_q[PW-1] && (plow != '0)) ? PW'(1) : PW'(0));

  assign r2 = {rem_q[DataW-1:0], 1'b0};
  assign qr = {1'b0, quo_q} + ((r2 >= {1'b0, den_q}) ? (NumW+1)'(1) : (NumW+1)'(0));
  assign sq = neg_q ? -$signed({1'b0, qr}) : $signed({1'b0, qr});

  assign ov_set = (take && !cmd_i.is_mul && !cmd_i.is_div) ||
                  (st_q == StMul && slot_free) ||
                  (st_q == StDiv && cnt_q == '0 && slot_free);

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: begin
        if (take && cmd_i.is_mul) st_d = StMul;
        else if (take && cmd_i.is_div) st_d = StDiv;
      end
      StMul: if (slot_free) st_d = StIdle;
      StDiv: if (cnt_q == '0 && slot_free) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (ov_set) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= PW'(cmd_i.a) * PW'(cmd_i.b);
      num_q  <= {ma, FracBits'(0)};
      den_q  <= mb;
      rem_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= CntW'(NumW);
      neg_q  <= cmd_i.a[DataW-1] ^ cmd_i.b[DataW-1];
      if (!cmd_i.is_mul && !cmd_i.is_div) begin
        out_q.result         <= cmd_i.res;
        out_q.overflow       <= cmd_i.ovf;
        out_q.divide_by_zero <= cmd_i.dbz;
      end
    end else if (st_q == StDiv && cnt_q != '0) begin
      num_q <= num_q << 1;
      cnt_q <= cnt_q - CntW'(1);
      if (!rdiff[DataW]) begin
        rem_q <= rdiff;
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rsh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end else if (st_q == StDiv && slot_free) begin
      out_q.result         <= sq[DataW-1:0];
      out_q.overflow       <= (sq[NumW+1:DataW-1] != '0) && (sq[NumW+1:DataW-1] != '1);
      out_q.divide_by_zero <= 1'b0;
    end else if (st_q == StMul && slot_free) begin
      out_q.result         <= pt[DataW-1:0];
      out_q.overflow       <= (pt[PW-1:DataW-1] != '0) && (pt[PW-1:DataW-1] != '1);
      out_q.divide_by_zero <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(st_q)) else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(out_q))
    else $error("result changed under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !cmd_ready_o) else $error("accept while busy");

endmodule

// ----- hw/rtl/fixed_point_alu_q24_8_unit.sv -----
// channel | dir | beat payload
// req     | in  | opcode[3:0], operand_a[31:0], operand_b[31:0]
// rsp     | out | result[31:0], overflow, divide_by_zero
// Simple ops: one beat per cycle when not stalled; front reg, queue slot, output reg.
// mul: in the back unit the product is registered, then shifted and wrapped.
// div: one quotient bit per cycle through the restoring divider.
// A 2-entry queue between front and back decouples their stalls.
// rst_ni is asynchronous, active low; it clears all valid and state flops.
module fixed_point_alu_q24_8_unit (
  input  logic clk_i,
  input  logic rst_ni,
  fpa_req_if.sink   req,
  fpa_rsp_if.source rsp
);
  import fpa_pkg::*;

  logic f_valid, f_ready, q_valid, q_ready;
  cmd_t f_cmd, q_cmd;

  fpa_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready), .in_data_i (req.data),
    .cmd_valid_o (f_valid), .cmd_ready_i (f_ready), .cmd_o (f_cmd)
  );

  fpa_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (f_ready), .wr_data_i (f_cmd),
    .rd_valid_o (q_valid), .rd_ready_i (q_ready), .rd_data_o (q_cmd)
  );

  fpa_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i (q_valid), .cmd_ready_o (q_ready), .cmd_i (q_cmd),
    .out_valid_o (rsp.valid), .out_ready_i (rsp.ready), .out_data_o (rsp.data)
  );

endmodule
